// File: rtl/core/look_at_view_matrix_unit_assert.svh
// Assertion macros for the look-at view matrix unit.
// Each macro expects a clock named clk and a synchronous reset named rst in scope.
`ifndef LOOK_AT_VIEW_MATRIX_UNIT_ASSERT_SVH
`define LOOK_AT_VIEW_MATRIX_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LAVM_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("look-at view matrix check failed");

// The consequent must hold in the cycle after the antecedent.
`define LAVM_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("look-at view matrix check failed");

`endif

// File: rtl/core/lavm_pkg.sv
`timescale 1ns / 1ps
package lavm_pkg;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_UP_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_UP_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_UP_Z = 2'd2;

  localparam logic signed [31:0] ONE_Q16 = 32'sd65536;
  localparam logic signed [31:0] SAT_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] SAT_MIN = 32'sh80000000;

  localparam logic [1:0] ROW_FIRST = 2'd0;
  localparam logic [1:0] ROW_LAST  = 2'd3;

  // Normalizer pipeline shape.
  localparam int SHIFT_STEPS = 6;
  localparam int SQRT_STEPS  = 32;
  localparam int DIV_STEPS   = 17;
  localparam int NORM_LAT    = 5 + SHIFT_STEPS + SQRT_STEPS + DIV_STEPS;

  typedef logic [2:0][63:0] wide_vec_t;
  typedef logic [2:0][17:0] unit_vec_t;

  typedef struct packed {
    logic valid;
    logic zero;
  } norm_ctl_t;

  typedef struct packed {
    logic signed [31:0] cam_x;
    logic signed [31:0] cam_y;
    logic signed [31:0] cam_z;
    logic signed [31:0] target_x;
    logic signed [31:0] target_y;
    logic signed [31:0] target_z;
  } lavm_in_t;

  typedef struct packed {
    logic [1:0]         row_index;
    logic signed [31:0] col0;
    logic signed [31:0] col1;
    logic signed [31:0] col2;
    logic signed [31:0] col3;
    logic               degenerate;
    logic               last;
  } lavm_out_t;

endpackage

// File: rtl/core/look_at_view_matrix_unit.sv
`timescale 1ns / 1ps
// Right-handed look-at view matrix builder in signed Q16.16.
// Input channel (in_valid/in_ready/in_data): one transfer carries a camera
// position and a target point. Output channel (out_valid/out_ready/out_data):
// each input yields four transfers, matrix rows 0 to 3 in order, with last set
// on row 3. Rows 0..2 hold the right, true-up and negated forward axes with the
// saturated translation in col3; row 3 is 0,0,0,1.0. A zero-length forward or
// right vector gives zero rows 0..2 and degenerate set on all four rows.
// The up vector comes from the write port (cfg_we/cfg_index/cfg_wdata); index
// 3 is ignored. Write it only while the unit is empty.
// Throughput is one matrix per four output rows, set by the single output
// channel carrying one row per cycle while out_ready is high. The datapath
// itself is a 128-stage pipeline (two normalizers, each with a 32-stage square
// root and a 17-stage divider) that can take an item every cycle; it advances
// as a whole whenever its last stage is empty or hands its matrix to the row
// sequencer.
// When the receiver stalls, the row sequencer holds the current row and the
// pipeline freezes behind it, so nothing is lost or repeated; in_ready drops
// once a finished matrix waits at the end of the pipeline.
// Reset clears all valid bits and loads the up vector with (0, 1.0, 0).
`include "look_at_view_matrix_unit_assert.svh"
module look_at_view_matrix_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  lavm_pkg::lavm_in_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output lavm_pkg::lavm_out_t                 out_data,
  input  logic                                cfg_we,
  input  logic [lavm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [31:0]                         cfg_wdata
);
  import lavm_pkg::*;

  localparam int N1_SIDE_W = 96;
  localparam int N2_SIDE_W = 1 + 54 + 96;

  // Up vector registers.
  logic signed [31:0] up_x, up_y, up_z;

  // Whole-pipeline advance and the hand-off into the row sequencer.
  logic adv, ser_load;

  // Entry stage: camera and exact 33-bit forward difference.
  logic               s0_valid;
  logic [2:0][31:0]   s0_cam;
  logic signed [32:0] s0_d [3];

  // First normalizer (forward axis).
  wide_vec_t          n1_in;
  norm_ctl_t          n1_ctl;
  unit_vec_t          n1_vec;
  logic [2:0][31:0]   n1_cam;
  logic signed [17:0] n1_f [3];

  // Cross product forward x up: products, then differences.
  logic               x0_valid, x0_degen;
  logic signed [17:0] x0_f [3];
  logic [2:0][31:0]   x0_cam;
  logic signed [49:0] x0_p [6];
  logic               x1_valid, x1_degen;
  unit_vec_t          x1_f;
  logic [2:0][31:0]   x1_cam;
  logic signed [50:0] x1_rc [3];

  // Second normalizer (right axis).
  wide_vec_t              n2_in;
  logic [N2_SIDE_W-1:0]   n2_side_out;
  norm_ctl_t              n2_ctl;
  unit_vec_t              n2_vec;
  logic                   n2_degen1;
  unit_vec_t              n2_f;
  logic [2:0][31:0]       n2_cam;
  logic signed [17:0]     n2_s  [3];
  logic signed [17:0]     n2_fs [3];

  // True up = right x forward: products, then rounded differences.
  logic               u0_valid, u0_degen;
  logic signed [17:0] u0_s [3];
  logic signed [17:0] u0_f [3];
  logic [2:0][31:0]   u0_cam;
  logic signed [35:0] u0_p [6];
  logic signed [37:0] u_sum [3];
  logic               u1_valid, u1_degen;
  logic signed [18:0] u1_ax [3][3];
  logic [2:0][31:0]   u1_cam;

  // Translations: products, rounded sums, negate and saturate.
  logic               d0_valid, d0_degen;
  logic signed [18:0] d0_ax [3][3];
  logic signed [50:0] d0_p  [3][3];
  logic signed [52:0] d_sum [3];
  logic               d1_valid, d1_degen;
  logic signed [18:0] d1_ax [3][3];
  logic signed [36:0] d1_rnd [3];
  logic signed [38:0] d1_neg [3];
  logic               d2_valid, d2_degen;
  logic signed [18:0] d2_ax [3][3];
  logic signed [31:0] d2_tr [3];

  // Row sequencer: holds one finished matrix and steps through its rows.
  logic [1:0]         row;
  logic               h_degen;
  logic signed [18:0] h_ax [3][3];
  logic signed [31:0] h_tr [3];

  // Configuration writes; an unknown index leaves every register alone.
  always_ff @(posedge clk) begin
    if (rst) begin
      up_x <= '0;
      up_y <= ONE_Q16;
      up_z <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_UP_X: up_x <= signed'(cfg_wdata);
        CFG_UP_Y: up_y <= signed'(cfg_wdata);
        CFG_UP_Z: up_z <= signed'(cfg_wdata);
        default: ;
      endcase
    end
  end

  assign ser_load = d2_valid && (!out_valid || (out_ready && (row == ROW_LAST)));
  assign adv      = !d2_valid || ser_load;
  assign in_ready = adv;

  // Valid bits of the top-level stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
      x0_valid <= 1'b0;
      x1_valid <= 1'b0;
      u0_valid <= 1'b0;
      u1_valid <= 1'b0;
      d0_valid <= 1'b0;
      d1_valid <= 1'b0;
      d2_valid <= 1'b0;
    end else if (adv) begin
      s0_valid <= in_valid;
      x0_valid <= n1_ctl.valid;
      x1_valid <= x0_valid;
      u0_valid <= n2_ctl.valid;
      u1_valid <= u0_valid;
      d0_valid <= u1_valid;
      d1_valid <= d0_valid;
      d2_valid <= d1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_cam[0] <= in_data.cam_x;
      s0_cam[1] <= in_data.cam_y;
      s0_cam[2] <= in_data.cam_z;
      s0_d[0]   <= 33'(in_data.target_x) - 33'(in_data.cam_x);
      s0_d[1]   <= 33'(in_data.target_y) - 33'(in_data.cam_y);
      s0_d[2]   <= 33'(in_data.target_z) - 33'(in_data.cam_z);
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) n1_in[c] = 64'(s0_d[c]);
  end

  lavm_norm #(
    .SIDE_W (N1_SIDE_W)
  ) u_norm_fwd (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_valid (s0_valid),
    .in_vec   (n1_in),
    .in_side  (s0_cam),
    .out_ctl  (n1_ctl),
    .out_vec  (n1_vec),
    .out_side (n1_cam)
  );

  always_comb begin
    for (int c = 0; c < 3; c++) n1_f[c] = signed'(n1_vec[c]);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x0_degen <= n1_ctl.zero;
      x0_cam   <= n1_cam;
      for (int c = 0; c < 3; c++) x0_f[c] <= n1_f[c];
      x0_p[0] <= 50'(n1_f[1]) * 50'(up_z);
      x0_p[1] <= 50'(n1_f[2]) * 50'(up_y);
      x0_p[2] <= 50'(n1_f[2]) * 50'(up_x);
      x0_p[3] <= 50'(n1_f[0]) * 50'(up_z);
      x0_p[4] <= 50'(n1_f[0]) * 50'(up_y);
      x0_p[5] <= 50'(n1_f[1]) * 50'(up_x);
      x1_degen <= x0_degen;
      x1_cam   <= x0_cam;
      for (int c = 0; c < 3; c++) begin
        x1_f[c]  <= x0_f[c];
        x1_rc[c] <= 51'(x0_p[2*c]) - 51'(x0_p[2*c+1]);
      end
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) n2_in[c] = 64'(x1_rc[c]);
  end

  lavm_norm #(
    .SIDE_W (N2_SIDE_W)
  ) u_norm_right (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_valid (x1_valid),
    .in_vec   (n2_in),
    .in_side  ({x1_degen, x1_f, x1_cam}),
    .out_ctl  (n2_ctl),
    .out_vec  (n2_vec),
    .out_side (n2_side_out)
  );

  assign {n2_degen1, n2_f, n2_cam} = n2_side_out;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      n2_s[c]  = signed'(n2_vec[c]);
      n2_fs[c] = signed'(n2_f[c]);
    end
  end

  // Round to nearest with ties up: add one half, keep bits 34:16.
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      u_sum[c] = 38'(u0_p[2*c]) - 38'(u0_p[2*c+1]) + 38'sd32768;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      u0_degen <= n2_degen1 | n2_ctl.zero;
      u0_cam   <= n2_cam;
      for (int c = 0; c < 3; c++) begin
        u0_s[c] <= n2_s[c];
        u0_f[c] <= n2_fs[c];
      end
      u0_p[0] <= 36'(n2_s[1]) * 36'(n2_fs[2]);
      u0_p[1] <= 36'(n2_s[2]) * 36'(n2_fs[1]);
      u0_p[2] <= 36'(n2_s[2]) * 36'(n2_fs[0]);
      u0_p[3] <= 36'(n2_s[0]) * 36'(n2_fs[2]);
      u0_p[4] <= 36'(n2_s[0]) * 36'(n2_fs[1]);
      u0_p[5] <= 36'(n2_s[1]) * 36'(n2_fs[0]);
      u1_degen <= u0_degen;
      u1_cam   <= u0_cam;
      for (int c = 0; c < 3; c++) begin
        u1_ax[0][c] <= 19'(u0_s[c]);
        u1_ax[1][c] <= u_sum[c][34:16];
        u1_ax[2][c] <= -(19'(u0_f[c]));
      end
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      d_sum[r] = 53'(d0_p[r][0]) + 53'(d0_p[r][1]) + 53'(d0_p[r][2]) + 53'sd32768;
      d1_neg[r] = -(39'(d1_rnd[r]));
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d0_degen <= u1_degen;
      d0_ax    <= u1_ax;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          d0_p[r][c] <= 51'(u1_ax[r][c]) * 51'(signed'(u1_cam[c]));
        end
      end
      d1_degen <= d0_degen;
      d1_ax    <= d0_ax;
      for (int r = 0; r < 3; r++) d1_rnd[r] <= d_sum[r][52:16];
      d2_degen <= d1_degen;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          d2_ax[r][c] <= d1_degen ? 19'sd0 : d1_ax[r][c];
        end
        if (d1_degen) begin
          d2_tr[r] <= '0;
        end else if (d1_neg[r] > 39'(SAT_MAX)) begin
          d2_tr[r] <= SAT_MAX;
        end else if (d1_neg[r] < 39'(SAT_MIN)) begin
          d2_tr[r] <= SAT_MIN;
        end else begin
          d2_tr[r] <= d1_neg[r][31:0];
        end
      end
    end
  end

  // Row sequencer. A new matrix loads when the sequencer is empty or its last
  // row is being taken in this same cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      row       <= ROW_FIRST;
    end else if (ser_load) begin
      out_valid <= 1'b1;
      row       <= ROW_FIRST;
    end else if (out_valid && out_ready) begin
      if (row == ROW_LAST) begin
        out_valid <= 1'b0;
      end else begin
        row <= row + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ser_load) begin
      h_degen <= d2_degen;
      h_ax    <= d2_ax;
      h_tr    <= d2_tr;
    end
  end

  always_comb begin
    out_data.row_index  = row;
    out_data.degenerate = h_degen;
    out_data.last       = (row == ROW_LAST);
    if (row == ROW_LAST) begin
      out_data.col0 = '0;
      out_data.col1 = '0;
      out_data.col2 = '0;
      out_data.col3 = ONE_Q16;
    end else begin
      out_data.col0 = 32'(h_ax[row][0]);
      out_data.col1 = 32'(h_ax[row][1]);
      out_data.col2 = 32'(h_ax[row][2]);
      out_data.col3 = h_tr[row];
    end
  end

  // Rows of one matrix leave in strict order.
  `LAVM_ASSERT_NXT(a_row_step, out_valid && out_ready && (out_data.row_index != ROW_LAST), out_valid && (out_data.row_index == $past(out_data.row_index) + 2'd1))

  // A degenerate matrix carries zero axis rows.
  `LAVM_ASSERT_IMP(a_degen_zero, out_valid && out_data.degenerate && (out_data.row_index != ROW_LAST), (out_data.col0 == 32'sd0) && (out_data.col1 == 32'sd0) && (out_data.col2 == 32'sd0) && (out_data.col3 == 32'sd0))

  // A waiting matrix follows the last row of the previous one without a gap.
  `LAVM_ASSERT_NXT(a_next_matrix, out_valid && out_ready && out_data.last && d2_valid, out_valid && (out_data.row_index == ROW_FIRST))

endmodule

// File: rtl/core/lavm_norm.sv
`timescale 1ns / 1ps
module lavm_norm #(
  parameter int SIDE_W = 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 adv,
  input  logic                 in_valid,
  input  lavm_pkg::wide_vec_t  in_vec,
  input  logic [SIDE_W-1:0]    in_side,
  output lavm_pkg::norm_ctl_t  out_ctl,
  output lavm_pkg::unit_vec_t  out_vec,
  output logic [SIDE_W-1:0]    out_side
);
  import lavm_pkg::*;

  // Control travels in a plain shift chain beside the data.
  logic              vld  [NORM_LAT];
  logic              zero [NORM_LAT];
  logic [SIDE_W-1:0] side [NORM_LAT];
  logic [2:0]        neg  [NORM_LAT-1];

  logic [2:0][63:0] mag [SHIFT_STEPS+1];
  logic [63:0]      orw [SHIFT_STEPS];
  logic [2:0][30:0] tsq;
  logic [2:0][61:0] sq;
  logic [63:0]      rn    [SQRT_STEPS];
  logic [63:0]      rr    [SQRT_STEPS+1];
  logic [63:0]      trial [SQRT_STEPS];
  logic [2:0][30:0] tq    [SQRT_STEPS+1];
  logic [2:0][47:0] rem   [DIV_STEPS];
  logic [31:0]      dlen  [DIV_STEPS];
  logic [47:0]      dsh   [DIV_STEPS];
  logic [2:0][16:0] quo   [DIV_STEPS+1];
  unit_vec_t        uvec;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NORM_LAT; i++) vld[i] <= 1'b0;
    end else if (adv) begin
      vld[0] <= in_valid;
      for (int i = 1; i < NORM_LAT; i++) vld[i] <= vld[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      neg[0]  <= {in_vec[2][63], in_vec[1][63], in_vec[0][63]};
      zero[0] <= (in_vec == '0);
      side[0] <= in_side;
      for (int i = 1; i < NORM_LAT; i++) begin
        zero[i] <= zero[i-1];
        side[i] <= side[i-1];
      end
      for (int i = 1; i < NORM_LAT - 1; i++) neg[i] <= neg[i-1];
    end
  end

  // Magnitudes, then a six-step shift that puts the leading one at bit 63.
  // OR of the magnitudes has the same leading one as their maximum.
  always_comb begin
    for (int j = 0; j < SHIFT_STEPS; j++) orw[j] = mag[j][0] | mag[j][1] | mag[j][2];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int c = 0; c < 3; c++) begin
        mag[0][c] <= in_vec[c][63] ? (64'd0 - in_vec[c]) : in_vec[c];
      end
      for (int j = 0; j < SHIFT_STEPS; j++) begin
        for (int c = 0; c < 3; c++) begin
          if ((orw[j] >> (64 - (32 >> j))) == 64'd0) begin
            mag[j+1][c] <= mag[j][c] << (32 >> j);
          end else begin
            mag[j+1][c] <= mag[j][c];
          end
        end
      end
    end
  end

  // Bits 63:33 are the magnitudes with the largest in [2^30, 2^31).
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int c = 0; c < 3; c++) begin
        tsq[c] <= mag[SHIFT_STEPS][c][63:33];
        sq[c]  <= 62'(mag[SHIFT_STEPS][c][63:33]) * 62'(mag[SHIFT_STEPS][c][63:33]);
      end
      rn[0] <= 64'(sq[0]) + 64'(sq[1]) + 64'(sq[2]);
      rr[0] <= '0;
      tq[0] <= tsq;
    end
  end

  // Floor square root, one result bit per stage.
  always_comb begin
    for (int k = 0; k < SQRT_STEPS; k++) trial[k] = rr[k] + (64'd1 << (62 - 2 * k));
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < SQRT_STEPS; k++) begin
        tq[k+1] <= tq[k];
        if (rn[k] >= trial[k]) begin
          if (k + 1 < SQRT_STEPS) rn[k+1] <= rn[k] - trial[k];
          rr[k+1] <= (rr[k] >> 1) + (64'd1 << (62 - 2 * k));
        end else begin
          if (k + 1 < SQRT_STEPS) rn[k+1] <= rn[k];
          rr[k+1] <= rr[k] >> 1;
        end
      end
    end
  end

  // Rounded division of each magnitude by the length, one quotient bit per stage.
  always_comb begin
    for (int j = 0; j < DIV_STEPS; j++) dsh[j] = 48'(dlen[j]) << (DIV_STEPS - 1 - j);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int c = 0; c < 3; c++) begin
        rem[0][c] <= {1'b0, tq[SQRT_STEPS][c], 16'd0} + 48'(rr[SQRT_STEPS][31:1]);
      end
      dlen[0] <= rr[SQRT_STEPS][31:0];
      quo[0]  <= '0;
      for (int j = 0; j < DIV_STEPS; j++) begin
        if (j + 1 < DIV_STEPS) dlen[j+1] <= dlen[j];
        for (int c = 0; c < 3; c++) begin
          if (rem[j][c] >= dsh[j]) begin
            if (j + 1 < DIV_STEPS) rem[j+1][c] <= rem[j][c] - dsh[j];
            quo[j+1][c] <= quo[j][c] | (17'd1 << (DIV_STEPS - 1 - j));
          end else begin
            if (j + 1 < DIV_STEPS) rem[j+1][c] <= rem[j][c];
            quo[j+1][c] <= quo[j][c];
          end
        end
      end
      for (int c = 0; c < 3; c++) begin
        uvec[c] <= neg[NORM_LAT-2][c] ? (18'd0 - {1'b0, quo[DIV_STEPS][c]})
                                      : {1'b0, quo[DIV_STEPS][c]};
      end
    end
  end

  assign out_ctl.valid = vld[NORM_LAT-1];
  assign out_ctl.zero  = zero[NORM_LAT-1];
  assign out_vec       = uvec;
  assign out_side      = side[NORM_LAT-1];

endmodule

// File: test/lavm_checker.sv
`timescale 1ns / 1ps
module lavm_checker (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_ready,
  input  lavm_pkg::lavm_in_t  in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  lavm_pkg::lavm_out_t out_data,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_wdata,
  output int                  errors,
  output int                  pending,
  output int                  rows_checked
);
  import lavm_pkg::*;

  typedef longint vec3_t [3];

  logic signed [31:0] up_vec [3];
  lavm_out_t row_queue [$];

  function automatic longint unsigned floor_sqrt(input longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // Round Q32.32 to Q16.16, ties toward plus infinity.
  function automatic longint round_q16(input longint v);
    return (v + 64'sd32768) >>> 16;
  endfunction

  function automatic bit unit_vector(input vec3_t v, output vec3_t o);
    longint unsigned mag [3];
    longint unsigned mx, sum, len, c;
    mx = 0;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = (v[i] < 0) ? longint'(-v[i]) : v[i];
      if (mag[i] > mx) mx = mag[i];
    end
    if (mx == 0) return 1'b0;
    while (mx >= (64'd1 << 31)) begin
      for (int i = 0; i < 3; i++) mag[i] >>= 1;
      mx >>= 1;
    end
    while (mx < (64'd1 << 30)) begin
      for (int i = 0; i < 3; i++) mag[i] <<= 1;
      mx <<= 1;
    end
    for (int i = 0; i < 3; i++) sum += mag[i] * mag[i];
    len = floor_sqrt(sum);
    for (int i = 0; i < 3; i++) begin
      c = ((mag[i] << 16) + (len >> 1)) / len;
      o[i] = (v[i] < 0) ? -longint'(c) : longint'(c);
    end
    return 1'b1;
  endfunction

  function automatic void cross3(input vec3_t a, input vec3_t b, output vec3_t r);
    r[0] = a[1] * b[2] - a[2] * b[1];
    r[1] = a[2] * b[0] - a[0] * b[2];
    r[2] = a[0] * b[1] - a[1] * b[0];
  endfunction

  // Builds the four matrix rows of one camera/target pair and queues them.
  task automatic predict_view_matrix(input lavm_in_t item);
    vec3_t cam, dir, up, fwd, raw, right, tup;
    longint cols [4][4];
    longint dot;
    bit degen;
    lavm_out_t row;
    cam[0] = item.cam_x;
    cam[1] = item.cam_y;
    cam[2] = item.cam_z;
    dir[0] = longint'(item.target_x) - cam[0];
    dir[1] = longint'(item.target_y) - cam[1];
    dir[2] = longint'(item.target_z) - cam[2];
    for (int i = 0; i < 3; i++) up[i] = up_vec[i];
    degen = 1'b0;
    if (!unit_vector(dir, fwd)) begin
      degen = 1'b1;
    end else begin
      cross3(fwd, up, raw);
      if (!unit_vector(raw, right)) degen = 1'b1;
    end
    for (int r = 0; r < 4; r++)
      for (int c = 0; c < 4; c++) cols[r][c] = 0;
    cols[3][3] = ONE_Q16;
    if (!degen) begin
      cross3(right, fwd, raw);
      for (int i = 0; i < 3; i++) begin
        cols[0][i] = right[i];
        cols[1][i] = round_q16(raw[i]);
        cols[2][i] = -fwd[i];
      end
      for (int r = 0; r < 3; r++) begin
        dot = 0;
        for (int i = 0; i < 3; i++) dot += cols[r][i] * cam[i];
        dot = -round_q16(dot);
        if (dot > longint'(SAT_MAX)) dot = SAT_MAX;
        if (dot < longint'(SAT_MIN)) dot = SAT_MIN;
        cols[r][3] = dot;
      end
    end
    for (int r = 0; r < 4; r++) begin
      row.row_index  = r[1:0];
      row.col0       = cols[r][0][31:0];
      row.col1       = cols[r][1][31:0];
      row.col2       = cols[r][2][31:0];
      row.col3       = cols[r][3][31:0];
      row.degenerate = degen;
      row.last       = (r[1:0] == ROW_LAST);
      row_queue.push_back(row);
    end
  endtask

  task automatic compare_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %h, got %h", $realtime, name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    lavm_out_t want;
    if (rst) begin
      up_vec[0] <= 32'sd0;
      up_vec[1] <= ONE_Q16;
      up_vec[2] <= 32'sd0;
      row_queue.delete();
      errors = 0;
      rows_checked <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_UP_X: up_vec[0] <= cfg_wdata;
          CFG_UP_Y: up_vec[1] <= cfg_wdata;
          CFG_UP_Z: up_vec[2] <= cfg_wdata;
          default: ;
        endcase
      end
      if (in_valid && in_ready) predict_view_matrix(in_data);
      if (out_valid && out_ready) begin
        rows_checked <= rows_checked + 1;
        if (row_queue.size() == 0) begin
          $display("%0t: unexpected row, got %p", $realtime, out_data);
          errors++;
        end else begin
          want = row_queue.pop_front();
          compare_field("row_index", 32'(want.row_index), 32'(out_data.row_index));
          compare_field("col0", want.col0, out_data.col0);
          compare_field("col1", want.col1, out_data.col1);
          compare_field("col2", want.col2, out_data.col2);
          compare_field("col3", want.col3, out_data.col3);
          compare_field("degenerate", 32'(want.degenerate), 32'(out_data.degenerate));
          compare_field("last", 32'(want.last), 32'(out_data.last));
        end
      end
    end
    pending = row_queue.size();
  end
endmodule

// File: test/tb.sv
`timescale 1ns / 1ps
module tb;
  import lavm_pkg::*;

  // Cycles of silence tolerated before the run is declared hung. The limit covers
  // the pipeline depth and the receiver stalls on each row.
  localparam int HANG_LIMIT = 5000;
  // Settling time after the last row, longer than the pipeline depth.
  localparam int SETTLE_CYCLES = 200;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  lavm_in_t in_data;
  logic out_valid;
  logic out_ready;
  lavm_out_t out_data;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [31:0] cfg_wdata;

  int errors;
  int pending;
  int rows_checked;
  int items_sent;
  int out_stall;
  int quiet_cycles;

  look_at_view_matrix_unit DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  lavm_checker checker_i (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .errors(errors), .pending(pending), .rows_checked(rows_checked)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // The receiver draws a fresh stall length after each row transfer; a zero
  // draw keeps it ready so rows can leave back to back. Only one assignment
  // to out_ready happens per edge.
  always @(posedge clk) begin
    int draw;
    draw = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
    if (rst) begin
      out_ready <= 1'b0;
      out_stall <= 0;
    end else if (out_valid && out_ready) begin
      out_stall <= (draw > 0) ? draw - 1 : 0;
      out_ready <= (draw == 0);
    end else if (out_stall > 0) begin
      out_stall <= out_stall - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Watchdog: counts cycles in which neither channel moves a transfer.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= HANG_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // Sends one camera/target pair. The task returns right after the transfer
  // edge with in_valid still high; the next call either lowers it for a gap or
  // replaces the payload at once, so in_valid gets one assignment per edge.
  task automatic send_pair(input lavm_in_t item, input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  task automatic send_idle_gap(input lavm_in_t item);
    int gap;
    gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(0, 15);
    send_pair(item, gap);
  endtask

  // Waits for every queued row, then lets the pipeline go quiet. The up
  // vector must only change while the unit is empty.
  task automatic drain;
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes all three up components, then a write to the unused index, which
  // the unit must ignore.
  task automatic load_up(input logic [31:0] ux, input logic [31:0] uy,
                         input logic [31:0] uz);
    cfg_we <= 1'b1;
    cfg_index <= CFG_UP_X;
    cfg_wdata <= ux;
    @(posedge clk);
    cfg_index <= CFG_UP_Y;
    cfg_wdata <= uy;
    @(posedge clk);
    cfg_index <= CFG_UP_Z;
    cfg_wdata <= uz;
    @(posedge clk);
    cfg_index <= CFG_IDX_W'(3);
    cfg_wdata <= $urandom;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic lavm_in_t make_pair(input logic [31:0] cx, input logic [31:0] cy,
                                         input logic [31:0] cz, input logic [31:0] tx,
                                         input logic [31:0] ty, input logic [31:0] tz);
    lavm_in_t p;
    p.cam_x = cx;
    p.cam_y = cy;
    p.cam_z = cz;
    p.target_x = tx;
    p.target_y = ty;
    p.target_z = tz;
    return p;
  endfunction

  // Mostly full-range random coordinates; some small scenes around the origin,
  // and now and then a target equal to the camera.
  function automatic lavm_in_t random_pair();
    lavm_in_t p;
    int sel;
    sel = $urandom_range(0, 9);
    p = make_pair($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    if (sel < 4) begin
      p.cam_x = $signed($urandom_range(0, 32'h1fffff)) - 32'sh100000;
      p.cam_y = $signed($urandom_range(0, 32'h1fffff)) - 32'sh100000;
      p.cam_z = $signed($urandom_range(0, 32'h1fffff)) - 32'sh100000;
      p.target_x = p.cam_x + $signed($urandom_range(0, 32'h3ffff)) - 32'sh20000;
      p.target_y = p.cam_y + $signed($urandom_range(0, 32'h3ffff)) - 32'sh20000;
      p.target_z = p.cam_z + $signed($urandom_range(0, 32'h3ffff)) - 32'sh20000;
    end else if (sel == 4) begin
      p.target_x = p.cam_x;
      p.target_y = p.cam_y;
      p.target_z = p.cam_z;
    end
    return p;
  endfunction

  task automatic random_batch(input int count);
    for (int i = 0; i < count; i++) send_idle_gap(random_pair());
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    items_sent = 0;
    quiet_cycles = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part with the reset up vector (0, 1.0, 0).
    send_pair(make_pair(0, 0, 0, 0, 0, 32'hffff0000), 0);
    // Target equals camera: forward has zero length.
    send_pair(make_pair(32'h12345, 32'h678, 32'h9, 32'h12345, 32'h678, 32'h9), 0);
    // Looking straight up the up vector: right has zero length.
    send_pair(make_pair(0, 0, 0, 0, 32'h00050000, 0), 3);
    send_pair(make_pair(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                        32'h80000000, 32'h80000000, 32'h80000000), 0);
    send_pair(make_pair(32'h80000000, 32'h80000000, 32'h80000000,
                        32'h7fffffff, 32'h7fffffff, 32'h7fffffff), 15);
    // Camera at the far corner with a tiny step: the true-up translation saturates.
    send_pair(make_pair(32'h7fffffff, 32'h80000000, 32'h7fffffff,
                        32'h7ffffffe, 32'h80000000, 32'h7fffffff), 0);
    send_pair(make_pair(32'h80000000, 32'h7fffffff, 32'h80000000,
                        32'h80000001, 32'h7fffffff, 32'h80000001), 1);
    send_pair(make_pair(32'hffffffff, 32'h1, 32'hffffffff, 32'h1, 32'hffffffff, 32'h1), 0);
    send_pair(make_pair(32'h00010000, 32'h00020000, 32'h00030000,
                        32'h00010000, 32'h00020000, 32'h00030001), 0);
    drain();

    // Extreme up vector, not of unit length.
    load_up(32'h7fffffff, 32'h80000000, 32'h00000001);
    send_pair(make_pair(0, 0, 0, 32'h00010000, 0, 0), 0);
    send_pair(make_pair(0, 0, 0, 32'h7fffffff, 32'h80000000, 32'h1), 0);
    send_pair(make_pair(32'h55555555, 32'haaaaaaaa, 32'h0f0f0f0f,
                        32'haaaaaaaa, 32'h55555555, 32'hf0f0f0f0), 2);
    random_batch(20);
    drain();

    // Zero up vector: every item is degenerate.
    load_up(32'h0, 32'h0, 32'h0);
    send_pair(make_pair(0, 0, 0, 32'h00010000, 32'h00010000, 32'h00010000), 0);
    send_pair(make_pair(32'h1, 32'h2, 32'h3, 32'h4, 32'h5, 32'h6), 0);
    random_batch(6);
    drain();

    // Random up vectors, one per phase.
    for (int ph = 0; ph < 3; ph++) begin
      load_up($urandom, $urandom, $urandom);
      random_batch(20);
      drain();
    end

    // Small up vector of the minimum nonzero size along z.
    load_up(32'h0, 32'h0, 32'h1);
    random_batch(15);
    drain();

    // Back to the conventional up vector for the last random stretch.
    load_up(32'h0, ONE_Q16, 32'h0);
    random_batch(25);
    drain();

    $display("Sent %0d camera/target pairs over eight up-vector settings.", items_sent);
    $display("Checked %0d matrix rows, %0d mismatches.", rows_checked, errors);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/lavm_pkg.sv
rtl/core/lavm_norm.sv
rtl/core/look_at_view_matrix_unit.sv
test/lavm_checker.sv
test/tb.sv
